// ===== rtl/hcr_pkg.sv =====
// Shared constants and transaction types for the haplotype class refiner.
package hcr_pkg;

	localparam int MAX_SAMPLES = 256;
	localparam int MAX_CLASSES = 256;

	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int CLS_W = $clog2(MAX_CLASSES);
	localparam int NS_W  = 9;
	localparam int CC_W  = 9;
	localparam int AL_W  = 8;
	localparam int MC_W  = 16;

	// search token walking from the target cell down to cell 0
	typedef struct packed {
		logic             vld;
		logic [CLS_W-1:0] p;
		logic             texcl;
		logic [MC_W-1:0]  tcnt;
		logic             seen;
		logic             found;
		logic [CLS_W-1:0] fcls;
	} tok_t;

	// broadcast of the sample being processed
	typedef struct packed {
		logic             launch;
		logic [IDX_W-1:0] idx;
		logic [AL_W-1:0]  allele;
	} qry_t;

	// update of the target cell
	typedef struct packed {
		logic             vld;
		logic [CLS_W-1:0] cls;
		logic             excl;
		logic [MC_W-1:0]  mcnt;
	} wr_t;

endpackage

// ===== rtl/hcr_cell.sv =====
// One sample cell: per-sample class state plus one stage of the search token chain.
module hcr_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [hcr_pkg::IDX_W-1:0]  cell_idx,
	input  logic                       clr,
	input  hcr_pkg::qry_t              qry,
	input  hcr_pkg::wr_t               wr,
	input  hcr_pkg::tok_t              tok_up,
	output hcr_pkg::tok_t              tok_dn
);
	import hcr_pkg::*;

	logic [CLS_W-1:0] cls_q;
	logic [CLS_W-1:0] prev_q;
	logic             excl_q;
	logic [MC_W-1:0]  mcnt_q;
	logic [AL_W-1:0]  allele_q;
	tok_t             tok_q;
	tok_t             tok_d;
	logic             hit;

	assign hit    = (cell_idx == qry.idx);
	assign tok_dn = tok_q;

	// a token coming from above only ever passes cells of earlier samples
	always_comb begin
		tok_d = tok_up;
		if (qry.launch && hit) begin
			tok_d       = '0;
			tok_d.vld   = 1'b1;
			tok_d.p     = cls_q;
			tok_d.texcl = excl_q;
			tok_d.tcnt  = mcnt_q;
		end else if (tok_up.vld && !excl_q && (prev_q == tok_up.p)) begin
			tok_d.seen = 1'b1;
			if (allele_q == qry.allele) begin
				tok_d.found = 1'b1;
				tok_d.fcls  = cls_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			cls_q  <= '0;
			excl_q <= 1'b0;
			mcnt_q <= '0;
		end else if (clr) begin
			tok_q  <= '0;
			cls_q  <= '0;
			excl_q <= 1'b0;
			mcnt_q <= '0;
		end else begin
			tok_q <= tok_d;
			if (wr.vld && hit) begin
				cls_q  <= wr.cls;
				excl_q <= wr.excl;
				mcnt_q <= wr.mcnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.vld && hit && !clr) begin
			prev_q   <= cls_q;
			allele_q <= qry.allele;
		end
	end

endmodule

// ===== rtl/hcr_ctrl.sv =====
// Sequencer: launches the search, resolves the class decision and drives the result.
module hcr_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clr,
	input  logic [hcr_pkg::NS_W-1:0]   n_eff,
	input  logic                       start,
	input  logic [hcr_pkg::AL_W-1:0]   allele,
	input  logic                       allele_missing,
	output logic                       busy,
	input  hcr_pkg::tok_t              tok_out,
	output hcr_pkg::qry_t              qry,
	output hcr_pkg::wr_t               wr,
	output logic                       done,
	output logic [hcr_pkg::IDX_W-1:0]  sample_index,
	output logic [hcr_pkg::CLS_W-1:0]  haplotype_id,
	output logic                       excluded,
	output logic [hcr_pkg::MC_W-1:0]   missing_count,
	output logic [hcr_pkg::CC_W-1:0]   haplotype_count,
	output logic                       status,
	output logic                       last_of_site
);
	import hcr_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LAUNCH = 2'd1;
	localparam logic [1:0] ST_WALK   = 2'd2;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic [AL_W-1:0]  allele_q;
	logic             miss_q;
	logic [IDX_W-1:0] smp_cnt_q;
	logic [CC_W-1:0]  cc_q;
	wr_t              wr_q;
	logic             done_q;
	logic [IDX_W-1:0] sidx_q;
	logic [CLS_W-1:0] hid_q;
	logic             excl_q;
	logic [MC_W-1:0]  mcnt_q;
	logic [CC_W-1:0]  hcnt_q;
	logic             stat_q;
	logic             last_q;

	logic [CLS_W-1:0] nx_cls;
	logic             nx_excl;
	logic [MC_W-1:0]  nx_cnt;
	logic             nx_stat;
	logic [CC_W-1:0]  nx_cc;
	logic [NS_W-1:0]  idx_p1;
	logic             nx_last;
	logic             accept;
	logic             finish;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign finish = (state_q == ST_WALK) && tok_out.vld;

	assign qry.launch = (state_q == ST_LAUNCH);
	assign qry.idx    = idx_q;
	assign qry.allele = allele_q;
	assign wr         = wr_q;

	assign idx_p1  = NS_W'(idx_q) + NS_W'(1);
	assign nx_last = (idx_p1 >= n_eff);

	always_comb begin
		nx_cls  = tok_out.p;
		nx_excl = tok_out.texcl;
		nx_cnt  = tok_out.tcnt;
		nx_stat = 1'b0;
		nx_cc   = cc_q;
		if (miss_q) begin
			nx_excl = 1'b1;
			if (tok_out.tcnt != '1) begin
				nx_cnt = tok_out.tcnt + MC_W'(1);
			end
		end else if (!tok_out.texcl) begin
			priority if (cc_q == '0) begin
				nx_cc  = CC_W'(1);
				nx_cls = '0;
			end else if (!tok_out.seen) begin
				nx_cls = tok_out.p;
			end else if (tok_out.found) begin
				nx_cls = tok_out.fcls;
			end else if (cc_q < CC_W'(MAX_CLASSES)) begin
				nx_cls = cc_q[CLS_W-1:0];
				nx_cc  = cc_q + CC_W'(1);
			end else begin
				nx_excl = 1'b1;
				nx_stat = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			smp_cnt_q <= '0;
			cc_q      <= '0;
			wr_q      <= '0;
			done_q    <= 1'b0;
		end else if (clr) begin
			state_q   <= ST_IDLE;
			smp_cnt_q <= '0;
			cc_q      <= '0;
			wr_q      <= '0;
			done_q    <= 1'b0;
		end else begin
			wr_q.vld <= finish;
			done_q   <= finish;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (tok_out.vld) begin
						state_q   <= ST_IDLE;
						wr_q.cls  <= nx_cls;
						wr_q.excl <= nx_excl;
						wr_q.mcnt <= nx_cnt;
						cc_q      <= nx_cc;
						smp_cnt_q <= nx_last ? '0 : idx_p1[IDX_W-1:0];
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q    <= smp_cnt_q;
			allele_q <= allele;
			miss_q   <= allele_missing;
		end
		if (finish) begin
			sidx_q <= idx_q;
			hid_q  <= nx_excl ? '0 : nx_cls;
			excl_q <= nx_excl;
			mcnt_q <= nx_cnt;
			hcnt_q <= nx_cc;
			stat_q <= nx_stat;
			last_q <= nx_last;
		end
	end

	assign done            = done_q;
	assign sample_index    = sidx_q;
	assign haplotype_id    = hid_q;
	assign excluded        = excl_q;
	assign missing_count   = mcnt_q;
	assign haplotype_count = hcnt_q;
	assign status          = stat_q;
	assign last_of_site    = last_q;

`ifndef NO_ASSERTIONS
	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == ST_WALK)
		else $error("result strobe without a finished walk");

	a_token_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tok_out.vld |-> state_q == ST_WALK)
		else $error("search token outside a walk");

	a_class_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cc_q <= CC_W'(MAX_CLASSES))
		else $error("class count beyond table size");

	a_counter_in_site: assert property (@(posedge clk) disable iff (!arst_n)
		NS_W'(smp_cnt_q) < n_eff)
		else $error("sample counter outside the site");

	a_status_excludes: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && stat_q) |-> excl_q)
		else $error("full-table status without exclusion");
`endif

endmodule

// ===== rtl/haplotype_class_refiner.sv =====
// Top level: configuration register, row of sample cells and the sequencer.
//
//  channel   handshake            payload
//  input     start / busy         allele, allele_missing
//  result    done (one cycle)     sample_index, haplotype_id, excluded, missing_count,
//                                 haplotype_count, status, last_of_site
//  config    psel/penable/pwrite  paddr, pwdata, prdata (num_samples at 0x0)
//
// For sample i of a site the search token steps one cell per cycle from cell i down
// to cell 0; the next sample is accepted only once the token reaches cell 0.
// busy is low again in the cycle done is high. Results cannot be stalled.
// Reset sets num_samples to 256 and clears the class count and each cell's class,
// exclusion and missing count; a num_samples write clears them and starts a new site.
module haplotype_class_refiner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  allele,
	input  logic        allele_missing,
	output logic        done,
	output logic [7:0]  sample_index,
	output logic [7:0]  haplotype_id,
	output logic        excluded,
	output logic [15:0] missing_count,
	output logic [8:0]  haplotype_count,
	output logic        status,
	output logic        last_of_site
);
	import hcr_pkg::*;

	localparam logic [1:0] REG_NUM_SAMPLES = 2'd0;

	logic [NS_W-1:0] num_q;
	logic [NS_W-1:0] n_eff;
	logic            cfg_wr;
	qry_t            qry;
	wr_t             wr;
	tok_t            tok_w [0:MAX_SAMPLES];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr == REG_NUM_SAMPLES) ? 32'(num_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NS_W'(MAX_SAMPLES);
		end else if (cfg_wr) begin
			num_q <= pwdata[NS_W-1:0];
		end
	end

	always_comb begin
		if (num_q == '0) begin
			n_eff = NS_W'(1);
		end else if (num_q > NS_W'(MAX_SAMPLES)) begin
			n_eff = NS_W'(MAX_SAMPLES);
		end else begin
			n_eff = num_q;
		end
	end

	assign tok_w[MAX_SAMPLES] = '0;

	for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
		hcr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.clr      (cfg_wr),
			.qry      (qry),
			.wr       (wr),
			.tok_up   (tok_w[g+1]),
			.tok_dn   (tok_w[g])
		);
	end

	hcr_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.clr             (cfg_wr),
		.n_eff           (n_eff),
		.start           (start),
		.allele          (allele),
		.allele_missing  (allele_missing),
		.busy            (busy),
		.tok_out         (tok_w[0]),
		.qry             (qry),
		.wr              (wr),
		.done            (done),
		.sample_index    (sample_index),
		.haplotype_id    (haplotype_id),
		.excluded        (excluded),
		.missing_count   (missing_count),
		.haplotype_count (haplotype_count),
		.status          (status),
		.last_of_site    (last_of_site)
	);

endmodule
